[rtl/pulse_pattern_matcher_core_macros.svh]
// ----------------------------------------------------------------------------
// Pulse pattern matcher assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef PULSE_PATTERN_MATCHER_CORE_MACROS_SVH
`define PULSE_PATTERN_MATCHER_CORE_MACROS_SVH

// same-cycle implication
`define PPM_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/ppm_pkg.sv]
// ----------------------------------------------------------------------------
// Pulse pattern matcher package
// Fixed field widths, register and request codes, divider interface structs.
// ----------------------------------------------------------------------------
`default_nettype none

package ppm_pkg;

	localparam int MS_W        = 16;
	localparam int TOL_W       = 16;
	localparam int MARGIN_W    = 8;
	localparam int IDX_W       = 5;
	localparam int CNT_OUT_W   = 6;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;
	localparam int MS_DIVISOR  = 1000;

	localparam logic [CNT_OUT_W-1:0] COUNT_MAX = 6'd63;
	localparam logic [MARGIN_W-1:0]  MISS_MARGIN_RESET = 8'd3;

	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MISS_MARGIN = 2'd1;

	localparam logic REQ_WRITE  = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	typedef struct packed {
		logic            start;
		logic [MS_W-1:0] ticks;
	} div_ctl_t;

	typedef struct packed {
		logic            done;
		logic [MS_W-1:0] ms;
	} div_stat_t;

endpackage

`default_nettype wire

[rtl/ppm_ram.sv]
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/ppm_div.sv]
// ----------------------------------------------------------------------------
// Tick to millisecond converter
// Scales ticks by the tick period, then divides by 1000 with a reciprocal
// multiply; one step per cycle, each step registered, done raised with the product.
// ----------------------------------------------------------------------------
`default_nettype none

module ppm_div
	import ppm_pkg::*;
#(
	parameter int TICK_US = 64
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire div_ctl_t  ctl,
	output div_stat_t      stat
);

	localparam int PW  = MS_W + $clog2(TICK_US + 1);
	localparam int KS  = PW + $clog2(MS_DIVISOR);
	localparam int MW  = PW + 1;
	localparam int PRW = PW + MW;
	localparam logic [MW-1:0] RECIP =
		MW'(((64'd1 << KS) + 64'(MS_DIVISOR) - 64'd1) / 64'(MS_DIVISOR));

	logic           busy_q;
	logic           done_q;
	logic [PW-1:0]  work_q;
	logic [PRW-1:0] prod_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			busy_q <= 1'b0;
			done_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			work_q <= PW'(ctl.ticks) * PW'(TICK_US);
		end
		if (busy_q) begin
			prod_q <= PRW'(work_q) * PRW'(RECIP);
		end
	end

	assign stat.done = done_q;
	assign stat.ms   = MS_W'(prod_q >> KS);

endmodule

`default_nettype wire

[rtl/pulse_pattern_matcher_core.sv]
// ----------------------------------------------------------------------------
// Pulse pattern matcher core
// Compares measured pulse periods with a stored table of expected periods.
// ----------------------------------------------------------------------------
// A beat with req_type 0 writes one table entry and leaves the core idle,
// ready for the next beat. A beat with req_type 1 is a sample: the tick to
// millisecond conversion (scale by TICK_US, then a reciprocal multiply for
// the divide by 1000) runs while the core waits in ST_DIVW, then the decide
// step loads the result into the output register and returns the core to
// idle, where the next beat can be accepted. On the first sample of a
// series the leading-zero scan runs beside the conversion, one table
// position per cycle, and each skipped position lengthens that sample.
// in_ready is low while a sample is worked on; a finished result sits in the
// output register and does not block a new beat, but the next sample waits
// in its decide step until that result is taken. Registers are to be
// written by the user through cfg_we only while idle; the block itself
// does not enforce this.
`default_nettype none

module pulse_pattern_matcher_core
	import ppm_pkg::*;
#(
	parameter int PATTERN_DEPTH = 32,
	parameter int TICK_US       = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  req_type,
	input  wire logic [IDX_W-1:0]      entry_index,
	input  wire logic [MS_W-1:0]       entry_value_ms,
	input  wire logic [MS_W-1:0]       sample_ticks,
	input  wire logic                  sample_last,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       sample_matched,
	output logic                       series_done,
	output logic                       pattern_accepted,
	output logic [CNT_OUT_W-1:0]       matched_count
);

	localparam int IW  = $clog2(PATTERN_DEPTH);
	localparam int PTW = $clog2(PATTERN_DEPTH + 1);
	localparam int NW  = ((PTW > MARGIN_W) ? PTW : MARGIN_W) + 2;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DIVW   = 4'b0100,
		ST_DECIDE = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [PTW-1:0]         ptr_q;
	logic [PATTERN_DEPTH-1:0] nz_q;
	logic [PTW-1:0]         nz_count_q;
	logic                   series_open_q;
	logic                   first_q;
	logic                   ok_q;
	logic [CNT_OUT_W-1:0]   match_q;
	logic [TOL_W-1:0]       tol_q;
	logic [MARGIN_W-1:0]    margin_q;
	logic                   last_q;
	logic                   out_valid_q;
	logic                   matched_q;
	logic                   done_q;
	logic                   accepted_q;
	logic [CNT_OUT_W-1:0]   count_q;

	logic                   in_fire;
	logic                   wr_fire;
	logic                   wr_ok;
	logic [IW-1:0]          widx;
	logic                   wr_nz;
	logic                   smp_fire;
	logic [IW-1:0]          ptr_idx;
	logic                   ptr_in;
	logic [MS_W-1:0]        ram_rdata;
	logic [MS_W-1:0]        e;
	logic                   hit;
	logic [CNT_OUT_W-1:0]   match_nx;
	logic                   first_nx;
	logic                   ok_nx;
	logic signed [NW-1:0]   need;
	logic                   accepted;
	logic                   out_load;
	div_ctl_t               div_ctl;
	div_stat_t              div_stat;

	assign in_ready = state_q == ST_IDLE;
	assign in_fire  = in_valid && in_ready;
	assign wr_fire  = in_fire && req_type == REQ_WRITE;
	assign smp_fire = in_fire && req_type == REQ_SAMPLE;
	assign wr_ok    = 32'(entry_index) < PATTERN_DEPTH;
	assign widx     = IW'(entry_index);
	assign wr_nz    = entry_value_ms != '0;

	assign ptr_idx  = ptr_q[IW-1:0];
	assign ptr_in   = ptr_q < PTW'(PATTERN_DEPTH);

	assign div_ctl.start = smp_fire;
	assign div_ctl.ticks = sample_ticks;

	ppm_div #(
		.TICK_US(TICK_US)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (div_ctl),
		.stat  (div_stat)
	);

	// read address follows the pointer; it is stable from the end of the scan through the decide step
	ppm_ram #(
		.WIDTH(MS_W),
		.DEPTH(PATTERN_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (wr_fire && wr_ok),
		.waddr(widx),
		.wdata(entry_value_ms),
		.raddr(ptr_idx),
		.rdata(ram_rdata)
	);

	always_comb begin
		e = (ptr_in && nz_q[ptr_idx]) ? ram_rdata : '0;
		hit = (e >= tol_q)
			&& (({1'b0, e} + {1'b0, tol_q}) > {1'b0, div_stat.ms})
			&& ((e - tol_q) < div_stat.ms);
		match_nx = match_q;
		first_nx = first_q;
		ok_nx    = ok_q;
		if (hit) begin
			if (match_q != COUNT_MAX) begin
				match_nx = match_q + CNT_OUT_W'(1);
			end
			first_nx = 1'b1;
			ok_nx    = 1'b1;
		end else if (first_q && e != '0) begin
			ok_nx = 1'b0;
		end
		need = signed'(NW'(nz_count_q)) - signed'(NW'(margin_q));
		accepted = last_q && (ok_nx || need <= signed'(NW'(match_nx)));
	end

	assign out_load = state_q == ST_DECIDE && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ptr_q         <= '0;
			nz_q          <= '0;
			nz_count_q    <= '0;
			series_open_q <= 1'b0;
			first_q       <= 1'b0;
			ok_q          <= 1'b0;
			match_q       <= '0;
			tol_q         <= '0;
			margin_q      <= MISS_MARGIN_RESET;
			last_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TOLERANCE:   tol_q    <= cfg_data[TOL_W-1:0];
					REG_MISS_MARGIN: margin_q <= cfg_data[MARGIN_W-1:0];
					default: ;
				endcase
			end

			if (wr_fire && wr_ok) begin
				nz_q[widx] <= wr_nz;
				if (nz_q[widx] && !wr_nz) begin
					nz_count_q <= nz_count_q - PTW'(1);
				end else if (!nz_q[widx] && wr_nz) begin
					nz_count_q <= nz_count_q + PTW'(1);
				end
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (smp_fire) begin
						last_q <= sample_last;
						if (!series_open_q) begin
							series_open_q <= 1'b1;
							first_q       <= 1'b0;
							ok_q          <= 1'b0;
							match_q       <= '0;
							ptr_q         <= '0;
							state_q       <= ST_SCAN;
						end else begin
							state_q <= ST_DIVW;
						end
					end
				end
				ST_SCAN: begin
					if (ptr_in && !nz_q[ptr_idx]) begin
						ptr_q <= ptr_q + PTW'(1);
					end else begin
						state_q <= ST_DIVW;
					end
				end
				ST_DIVW: begin
					if (div_stat.done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (out_load) begin
						match_q <= match_nx;
						first_q <= first_nx;
						ok_q    <= ok_nx;
						if (first_nx && ptr_in) begin
							ptr_q <= ptr_q + PTW'(1);
						end
						if (last_q) begin
							series_open_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			matched_q  <= hit;
			done_q     <= last_q;
			accepted_q <= accepted;
			count_q    <= match_nx;
		end
	end

	assign out_valid        = out_valid_q;
	assign sample_matched   = matched_q;
	assign series_done      = done_q;
	assign pattern_accepted = accepted_q;
	assign matched_count    = count_q;

endmodule

`default_nettype wire

[rtl/ppm_checker.sv]
// ----------------------------------------------------------------------------
// Pulse pattern matcher port checker
// Watches the top level ports over time and flags inconsistent behavior.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pulse_pattern_matcher_core_macros.svh"

module ppm_checker
	import ppm_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	input  wire logic                  in_ready,
	input  wire logic                  req_type,
	input  wire logic                  out_valid,
	input  wire logic                  out_ready,
	input  wire logic                  sample_matched,
	input  wire logic                  series_done,
	input  wire logic                  pattern_accepted,
	input  wire logic [CNT_OUT_W-1:0]  matched_count
);

	`PPM_ASSERT_IMPLY(a_verdict_only_at_end, clk, arst_n,
		out_valid && !series_done, !pattern_accepted, "verdict outside series end")

	`PPM_ASSERT_IMPLY(a_match_counted, clk, arst_n,
		out_valid && sample_matched, matched_count != '0, "match without count")

	`PPM_ASSERT_NEXT(a_sample_busy, clk, arst_n,
		in_valid && in_ready && req_type == REQ_SAMPLE, !in_ready, "ready after sample beat")

	`PPM_ASSERT_NEXT(a_out_hold, clk, arst_n,
		out_valid && !out_ready,
		out_valid && $stable({sample_matched, series_done, pattern_accepted, matched_count}),
		"stalled result changed")

endmodule

bind pulse_pattern_matcher_core ppm_checker u_ppm_checker (.*);

`default_nettype wire
